>>> rtl/core/rdzbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdzbd_pkg
// Types, constants and tables shared by the run-length block decoder.
// ----------------------------------------------------------------------------
package rdzbd_pkg;

  localparam int unsigned BLOCK_SIZE      = 64;
  localparam int unsigned NUM_QWORDS      = 8;
  localparam int unsigned CFG_INDEX_W     = 4;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] PAD_WORD  = 16'hfe00;
  localparam logic [7:0]  PLAIN_Q   = 8'd2;
  localparam int unsigned PROD_W    = 19;   // 10-bit signed x 9-bit signed
  localparam int unsigned SCALED_W  = 27;   // product x scale, plus rounding
  localparam logic signed [SCALED_W-1:0] ROUND_ADD = SCALED_W'(4);
  localparam logic signed [SCALED_W-1:0] TRUNC_ADJ = SCALED_W'(7);
  localparam logic signed [SCALED_W-1:0] CLAMP_LO  = -SCALED_W'(1024);
  localparam logic signed [SCALED_W-1:0] CLAMP_HI  = SCALED_W'(1023);

  // Input word and result word
  typedef struct packed {
    logic [15:0] code_word;
    logic        final_word;
  } word_t;

  typedef struct packed {
    logic signed [10:0] coeff_value;
    logic [5:0]         coeff_index;
    logic               block_last;
    logic               decode_error;
  } coeff_t;

  // Command passed from the front end to the back end
  typedef struct packed {
    logic              do_store;
    logic              do_drain;
    logic              do_err;
    logic              scaled;
    logic signed [9:0] ac;
    logic [7:0]        q;
    logic [5:0]        scale;
    logic [5:0]        idx;
  } op_t;

  // Scan order to raster position
  localparam logic [5:0] ZIGZAG [BLOCK_SIZE] = '{
     0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
  };

  // Saturate a wide signed value to the 11-bit coefficient range
  function automatic logic signed [10:0] clamp11(input logic signed [SCALED_W-1:0] v);
    logic signed [10:0] r;
    if (v < CLAMP_LO) begin
      r = CLAMP_LO[10:0];
    end else if (v > CLAMP_HI) begin
      r = CLAMP_HI[10:0];
    end else begin
      r = v[10:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/rdzbd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdzbd_queue
// Small command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rdzbd_queue #(
  parameter int unsigned DEPTH = rdzbd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rdzbd_pkg::op_t push_op,
  output logic                full,
  input  wire logic           pop,
  output rdzbd_pkg::op_t      head,
  output logic                empty
);
  import rdzbd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Store pushed command
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue occupancy beyond depth");
`endif

endmodule
`default_nettype wire

>>> rtl/core/rdzbd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdzbd_front
// Accepts code words, tracks block position and turns them into store, drain
// or error commands, skipping padding between blocks; holds the quant table registers.
// ----------------------------------------------------------------------------
module rdzbd_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             word_valid,
  input  wire rdzbd_pkg::word_t                 word,
  output logic                                  word_stall,
  input  wire logic                             write_enable,
  input  wire logic [rdzbd_pkg::CFG_INDEX_W-1:0] reg_index,
  input  wire logic [rdzbd_pkg::CFG_DATA_W-1:0]  write_data,
  output logic                                  push,
  output rdzbd_pkg::op_t                        push_op,
  input  wire logic                             full
);
  import rdzbd_pkg::*;

  logic [CFG_DATA_W-1:0] qword [NUM_QWORDS];
  logic                  in_block;
  logic [5:0]            position;
  logic [5:0]            scale;

  logic                  in_block_next;
  logic [5:0]            position_next;
  logic [5:0]            scale_next;

  logic                  accept;
  logic [6:0]            run_sum;
  logic [5:0]            hdr_scale;
  logic [5:0]            n;
  logic [7:0]            q0;
  logic [7:0]            qn;
  logic [CFG_DATA_W-1:0] qsel;
  op_t                   op;

  assign word_stall = full;
  assign accept     = word_valid && !word_stall;
  assign hdr_scale  = word.code_word[15:10];
  assign run_sum    = {1'b0, position} + {1'b0, word.code_word[15:10]} + 7'd1;
  assign n          = run_sum[5:0];
  assign q0         = qword[0][7:0];
  assign qsel       = qword[n[5:3]];
  assign qn         = qsel[{n[2:0], 3'b000} +: 8];

  // Quant table writes; indexes beyond the table are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QWORDS; i++) begin
        qword[i] <= '0;
      end
    end else if (write_enable && (reg_index < CFG_INDEX_W'(NUM_QWORDS))) begin
      qword[reg_index[$clog2(NUM_QWORDS)-1:0]] <= write_data;
    end
  end

  // Classify the word and build its command
  always_comb begin
    op            = '0;
    in_block_next = in_block;
    position_next = position;
    scale_next    = scale;
    if (!in_block) begin
      if (word.code_word != PAD_WORD) begin
        op.do_store   = 1'b1;
        op.ac         = word.code_word[9:0];
        op.idx        = ZIGZAG[0];
        op.scaled     = 1'b0;
        op.q          = (hdr_scale != '0) ? q0 : PLAIN_Q;
        op.scale      = hdr_scale;
        scale_next    = hdr_scale;
        in_block_next = 1'b1;
        position_next = '0;
      end
      if (word.final_word) begin
        op.do_err     = 1'b1;
        in_block_next = 1'b0;
        position_next = '0;
      end
    end else if (run_sum[6]) begin
      op.do_drain   = 1'b1;
      in_block_next = 1'b0;
      position_next = '0;
    end else begin
      op.do_store   = 1'b1;
      op.ac         = word.code_word[9:0];
      op.scaled     = (scale != '0);
      op.scale      = scale;
      op.q          = (scale != '0) ? qn : PLAIN_Q;
      op.idx        = (scale != '0) ? ZIGZAG[n] : n;
      position_next = n;
      if (word.final_word) begin
        op.do_err     = 1'b1;
        in_block_next = 1'b0;
        position_next = '0;
      end
    end
  end

  assign push    = accept && (op.do_store || op.do_drain || op.do_err);
  assign push_op = op;

  // Block state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_block <= 1'b0;
      position <= '0;
      scale    <= '0;
    end else if (accept) begin
      in_block <= in_block_next;
      position <= position_next;
      scale    <= scale_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rdzbd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdzbd_back
// Executes commands: dequantizes into the coefficient store, drains a
// finished block in raster order and emits error words.
// ----------------------------------------------------------------------------
module rdzbd_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rdzbd_pkg::op_t head,
  input  wire logic        empty,
  output logic             pop,
  output logic             coeff_valid,
  output rdzbd_pkg::coeff_t coeff,
  input  wire logic        coeff_stall
);
  import rdzbd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_ERR   = 4'b1000
  } state_t;

  state_t                    state;
  state_t                    state_next;

  // Latched command
  logic signed [PROD_W-1:0]  prod;
  logic [5:0]                op_scale;
  logic [5:0]                op_idx;
  logic                      op_scaled;
  logic                      op_err;

  // Coefficient store and its written flags
  logic signed [10:0]        store [BLOCK_SIZE];
  logic [BLOCK_SIZE-1:0]     written_mask;
  logic [5:0]                drain_cnt;

  // Read slot in front of the output register
  logic signed [10:0]        rd_data;
  logic                      rd_pending;
  logic                      rd_mem_valid;
  logic [5:0]                rd_index;
  logic                      rd_last;
  logic                      rd_err;

  logic                      rd_move;
  logic                      slot_free;
  logic                      rd_issue;
  logic                      err_load;
  logic signed [SCALED_W-1:0] scaled_prod;
  logic signed [SCALED_W-1:0] rounded;
  logic signed [SCALED_W-1:0] quot;
  logic signed [10:0]        wr_value;
  coeff_t                    out_word;

  assign rd_move   = rd_pending && (!coeff_valid || !coeff_stall);
  assign slot_free = !rd_pending || rd_move;
  assign rd_issue  = (state == ST_DRAIN) && slot_free;
  assign err_load  = (state == ST_ERR) && slot_free;
  assign pop       = (state == ST_IDLE) && !empty;

  // Scale, round toward zero after the divide by eight, and saturate
  assign scaled_prod = SCALED_W'(prod) * $signed({1'b0, op_scale});
  assign rounded     = scaled_prod + ROUND_ADD;
  assign quot        = rounded[SCALED_W-1] ? ((rounded + TRUNC_ADJ) >>> 3) : (rounded >>> 3);
  assign wr_value    = op_scaled ? clamp11(quot) : clamp11(SCALED_W'(prod));

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          if (head.do_drain) begin
            state_next = ST_DRAIN;
          end else if (head.do_store) begin
            state_next = ST_MUL;
          end else begin
            state_next = ST_ERR;
          end
        end
      end
      ST_MUL: begin
        state_next = op_err ? ST_ERR : ST_IDLE;
      end
      ST_DRAIN: begin
        if (rd_issue && (drain_cnt == 6'(BLOCK_SIZE - 1))) begin
          state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (err_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch command and first product
  always_ff @(posedge clk) begin
    if (pop) begin
      prod      <= head.ac * $signed({1'b0, head.q});
      op_scale  <= head.scale;
      op_idx    <= head.idx;
      op_scaled <= head.scaled;
      op_err    <= head.do_err;
    end
  end

  // Coefficient store write and drain read
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      store[op_idx] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data <= store[drain_cnt];
    end
  end

  // Written flags: set on store, clear when the block closes
  always_ff @(posedge clk) begin
    if (rst) begin
      written_mask <= '0;
    end else if (state == ST_MUL) begin
      written_mask[op_idx] <= 1'b1;
    end else if ((rd_issue && (drain_cnt == 6'(BLOCK_SIZE - 1))) || err_load) begin
      written_mask <= '0;
    end
  end

  // Drain counter
  always_ff @(posedge clk) begin
    if (rst) begin
      drain_cnt <= '0;
    end else if (pop) begin
      drain_cnt <= '0;
    end else if (rd_issue) begin
      drain_cnt <= drain_cnt + 1'b1;
    end
  end

  // Read slot
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else if (rd_issue || err_load) begin
      rd_pending <= 1'b1;
    end else if (rd_move) begin
      rd_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_mem_valid <= written_mask[drain_cnt];
      rd_index     <= drain_cnt;
      rd_last      <= (drain_cnt == 6'(BLOCK_SIZE - 1));
      rd_err       <= 1'b0;
    end else if (err_load) begin
      rd_mem_valid <= 1'b0;
      rd_index     <= '0;
      rd_last      <= 1'b1;
      rd_err       <= 1'b1;
    end
  end

  always_comb begin
    out_word.coeff_value  = (rd_mem_valid && !rd_err) ? rd_data : '0;
    out_word.coeff_index  = rd_index;
    out_word.block_last   = rd_last;
    out_word.decode_error = rd_err;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_valid <= 1'b0;
    end else if (rd_move) begin
      coeff_valid <= 1'b1;
    end else if (!coeff_stall) begin
      coeff_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_move) begin
      coeff <= out_word;
    end
  end

`ifndef SYNTHESIS
  a_mul_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |=> state != ST_MUL)
    else $error("multiply step held longer than one cycle");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    coeff_valid && coeff.decode_error |->
      coeff.block_last && (coeff.coeff_value == '0) && (coeff.coeff_index == '0))
    else $error("malformed error word");

  a_mask_cleared: assert property (@(posedge clk) disable iff (rst)
    rd_issue && (drain_cnt == 6'(BLOCK_SIZE - 1)) |=> written_mask == '0)
    else $error("written flags not cleared after drain");
`endif

endmodule
`default_nettype wire

>>> rtl/core/rle_dequant_zigzag_block_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rle_dequant_zigzag_block_decoder_top
// Run-length decoder with dequantization and zigzag reordering for 8x8 blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel word/word_valid/word_stall carries one 16-bit code word and
//   its end-of-input flag per handshake. Output channel coeff/coeff_valid/
//   coeff_stall carries one coefficient word per handshake: 64 words in
//   raster order per block (block_last on the 64th), or a single error word.
//   The quant table is eight 64-bit registers written through write_enable,
//   reg_index and write_data; load it while the block is idle.
// Timing:
//   The front end takes one word per cycle while its command queue has room.
//   The back end takes a stored coefficient's command and forms the product,
//   then scales, rounds and stores it; an error word follows its command (after
//   the store when it comes with one), and a block drain takes the command and
//   then does one read per word, paced by the single coefficient store port. A
//   drain word passes through the command queue, the read slot and the output
//   register after the completing word is accepted.
// Reset: rst clears block state, the quant table and all queued commands.
// Stall: coeff_stall holds the output word; the back end and then the queue
//   back up, and word_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module rle_dequant_zigzag_block_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = rdzbd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              word_valid,
  input  wire rdzbd_pkg::word_t                  word,
  output logic                                   word_stall,
  output logic                                   coeff_valid,
  output rdzbd_pkg::coeff_t                      coeff,
  input  wire logic                              coeff_stall,
  input  wire logic                              write_enable,
  input  wire logic [rdzbd_pkg::CFG_INDEX_W-1:0] reg_index,
  input  wire logic [rdzbd_pkg::CFG_DATA_W-1:0]  write_data
);
  import rdzbd_pkg::*;

  logic push;
  op_t  push_op;
  logic full;
  logic pop;
  op_t  head;
  logic empty;

  rdzbd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (word_valid),
    .word         (word),
    .word_stall   (word_stall),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .push         (push),
    .push_op      (push_op),
    .full         (full)
  );

  rdzbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .head    (head),
    .empty   (empty)
  );

  rdzbd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .coeff_valid (coeff_valid),
    .coeff       (coeff),
    .coeff_stall (coeff_stall)
  );

endmodule
`default_nettype wire

>>> dv/rle_dequant_zigzag_block_decoder_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_dequant_zigzag_block_decoder_top_test
// Self-checking bench for the run-length block decoder. It runs a short
// directed table, then random blocks, broken blocks and noise. Each accepted
// code word is fed to an in-bench decoder model, and every coefficient word
// that leaves the block is compared with the oldest predicted one. Both
// channels idle at random, the receiver holds off once for a long stretch,
// and the quant table is reloaded between phases.
// ----------------------------------------------------------------------------
module rle_dequant_zigzag_block_decoder_top_test;
  import rdzbd_pkg::word_t;
  import rdzbd_pkg::coeff_t;

  localparam logic [3:0] QTABLE_WORD0  = 4'd0;
  localparam int         NUM_QWORDS    = 8;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         SETTLE_CYCLES = 24;
  localparam int         TAIL_CYCLES   = 40;
  localparam int         RANDOM_WORDS  = 100;
  localparam int         SHOW_LIMIT    = 10;
  localparam coeff_t     TRUNCATED_WORD = '{coeff_value: 11'sd0, coeff_index: 6'd0,
                                            block_last: 1'b1, decode_error: 1'b1};

  typedef struct packed {
    bit          is_load;
    logic [63:0] qval;
    word_t       w;
    bit          typed;
    coeff_t      res;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        word_valid;
  word_t       word;
  logic        word_stall;
  logic        coeff_valid;
  coeff_t      coeff;
  logic        coeff_stall;
  logic        write_enable;
  logic [3:0]  reg_index;
  logic [63:0] write_data;

  // Decoder model state
  logic [63:0]        qtab [NUM_QWORDS];
  logic signed [10:0] cstore [64];
  logic [63:0]        cmask;
  logic [6:0]         cpos;
  logic [5:0]         cscale;
  bit                 blk_open;
  coeff_t             step_res [64];

  coeff_t coeff_due [$];
  coeff_t want;
  int     fault_count;
  int     words_used;
  bit     tx_calm;
  bit     rx_calm;
  bit     rx_hold_req;

  rle_dequant_zigzag_block_decoder_top DUT (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (word_valid),
    .word         (word),
    .word_stall   (word_stall),
    .coeff_valid  (coeff_valid),
    .coeff        (coeff),
    .coeff_stall  (coeff_stall),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Quant table entry n
  function automatic int q_entry(input int n);
    return int'(qtab[n / 8][8 * (n % 8) +: 8]);
  endfunction

  function automatic logic signed [10:0] sat_level(input int v);
    if (v < -1024) return -11'sd1024;
    if (v > 1023) return 11'sd1023;
    return 11'(v);
  endfunction

  // Place a level at scan position n, zigzagged when the block is scaled
  function automatic void store_level(input int n, input int v);
    int spot;
    spot = (cscale != 0) ? int'(rdzbd_pkg::ZIGZAG[n]) : n;
    cstore[spot] = sat_level(v);
    cmask[spot]  = 1'b1;
  endfunction

  function automatic void close_block();
    blk_open = 1'b0;
    cpos     = '0;
    cmask    = '0;
  endfunction

  // Advance the model by one code word; results land in step_res
  function automatic int decode_word(input word_t w);
    int lvl;
    int n;
    int v;
    lvl = int'($signed(w.code_word[9:0]));
    if (!blk_open) begin
      if (w.code_word != rdzbd_pkg::PAD_WORD) begin
        cscale   = w.code_word[15:10];
        blk_open = 1'b1;
        cpos     = '0;
        cmask    = '0;
        store_level(0, (cscale != 0) ? lvl * q_entry(0) : lvl * 2);
      end
    end else begin
      n = int'(cpos) + int'(w.code_word[15:10]) + 1;
      if (n >= 64) begin
        for (int i = 0; i < 64; i++) begin
          step_res[i].coeff_value  = cmask[i] ? cstore[i] : 11'sd0;
          step_res[i].coeff_index  = 6'(i);
          step_res[i].block_last   = (i == 63);
          step_res[i].decode_error = 1'b0;
        end
        close_block();
        return 64;
      end
      cpos = 7'(n);
      if (cscale != 0) begin
        v = (lvl * q_entry(n) * int'(cscale) + 4) / 8;
      end else begin
        v = lvl * 2;
      end
      store_level(n, v);
    end
    if (w.final_word) begin
      close_block();
      step_res[0] = TRUNCATED_WORD;
      return 1;
    end
    return 0;
  endfunction

  function automatic plan_row_t word_row(input logic [15:0] cw, input logic fin);
    plan_row_t r;
    r = '0;
    r.w.code_word  = cw;
    r.w.final_word = fin;
    return r;
  endfunction

  // Word carrying the end flag short of a complete block: one error word
  function automatic plan_row_t cut_row(input logic [15:0] cw);
    plan_row_t r;
    r = word_row(cw, 1'b1);
    r.typed = 1'b1;
    r.res   = TRUNCATED_WORD;
    return r;
  endfunction

  function automatic plan_row_t load_row(input logic [63:0] v);
    plan_row_t r;
    r = '0;
    r.is_load = 1'b1;
    r.qval    = v;
    return r;
  endfunction

  // Offer one code word and predict once it is taken
  task automatic send_word(input logic [15:0] cw, input logic fin,
                           input bit typed, input coeff_t res);
    int cnt;
    @(negedge clk);
    while (!tx_calm && $urandom_range(99) < 33) begin
      word_valid = 1'b0;
      @(negedge clk);
    end
    word_valid      = 1'b1;
    word.code_word  = cw;
    word.final_word = fin;
    forever begin
      @(posedge clk);
      if (!word_stall) break;
    end
    if (blk_open || cw != rdzbd_pkg::PAD_WORD || fin) words_used++;
    cnt = decode_word(word);
    if (typed) begin
      coeff_due.push_back(res);
    end else begin
      for (int i = 0; i < cnt; i++) coeff_due.push_back(step_res[i]);
    end
  endtask

  // Let the block drain, then rewrite the whole quant table
  task automatic reload_qtable(input bit scramble, input logic [63:0] fill);
    logic [63:0] v;
    int pick;
    @(negedge clk);
    word_valid = 1'b0;
    while (coeff_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    for (int r = 0; r < NUM_QWORDS; r++) begin
      v = fill;
      if (scramble) begin
        for (int b = 0; b < 8; b++) begin
          pick = $urandom_range(0, 9);
          v[8 * b +: 8] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom);
        end
      end
      write_enable = 1'b1;
      reg_index    = QTABLE_WORD0 + 4'(r);
      write_data   = v;
      qtab[r]      = v;
      @(negedge clk);
    end
    write_enable = 1'b0;
  endtask

  // Header then run words; a cut block ends early with the end flag
  task automatic send_block(input bit cut);
    logic [5:0] scale;
    logic [5:0] run;
    int stop_at;
    int cnt;
    int pick;
    repeat ($urandom_range(0, 2)) send_word(rdzbd_pkg::PAD_WORD, 1'b0, 1'b0, '0);
    pick  = $urandom_range(0, 9);
    scale = (pick < 2) ? 6'd0 : (pick < 4) ? 6'd63 : 6'($urandom_range(1, 62));
    stop_at = cut ? $urandom_range(0, 6) : -1;
    send_word({scale, 10'($urandom)}, stop_at == 0, 1'b0, '0);
    cnt = 0;
    while (blk_open) begin
      cnt++;
      pick = $urandom_range(0, 99);
      run  = (pick < 80) ? 6'($urandom_range(0, 7)) :
             (pick < 95) ? 6'($urandom_range(8, 30)) : 6'd63;
      send_word({run, 10'($urandom)}, cnt == stop_at, 1'b0, '0);
    end
  endtask

  // Drive the output stall: one long hold-off on request, else random gaps
  initial begin
    int hold_left;
    coeff_stall = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        hold_left   = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        coeff_stall = 1'b1;
        hold_left--;
      end else begin
        coeff_stall = !rx_calm && ($urandom_range(99) < 33);
      end
    end
  end

  // Check each coefficient word against the oldest prediction
  task automatic log_fault(input string what, input coeff_t got, input coeff_t exp);
    fault_count++;
    if (fault_count <= SHOW_LIMIT) begin
      $display("[%0t] %s: got value %0d index %0d last %0b error %0b", $time, what,
               got.coeff_value, got.coeff_index, got.block_last, got.decode_error);
      $display("    expected value %0d index %0d last %0b error %0b",
               exp.coeff_value, exp.coeff_index, exp.block_last, exp.decode_error);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && coeff_valid && !coeff_stall) begin
      if (coeff_due.size() == 0) begin
        log_fault("coefficient word with nothing pending", coeff, '0);
      end else begin
        want = coeff_due.pop_front();
        if (coeff.coeff_value !== want.coeff_value ||
            coeff.coeff_index !== want.coeff_index ||
            coeff.block_last !== want.block_last ||
            coeff.decode_error !== want.decode_error) begin
          log_fault("coefficient mismatch", coeff, want);
        end
      end
    end
  end

  initial begin
    plan_row_t plan [$];
    plan_row_t row;
    int seq;
    int pick;

    rst          = 1'b1;
    word_valid   = 1'b0;
    word         = '0;
    write_enable = 1'b0;
    reg_index    = '0;
    write_data   = '0;
    fault_count  = 0;
    words_used   = 0;
    for (int r = 0; r < NUM_QWORDS; r++) qtab[r] = '0;
    for (int i = 0; i < 64; i++) cstore[i] = '0;
    cscale = '0;
    close_block();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed table
    plan.push_back(load_row(64'h0));
    plan.push_back(cut_row(rdzbd_pkg::PAD_WORD));     // padding with end flag, no block
    plan.push_back(word_row(16'h01ff, 1'b0));         // unscaled header, largest DC
    plan.push_back(word_row(16'h0200, 1'b0));         // most negative level
    plan.push_back(word_row(16'h0c01, 1'b0));         // run of three
    plan.push_back(word_row(rdzbd_pkg::PAD_WORD, 1'b1)); // padding inside block closes it
    plan.push_back(load_row(64'hffff_ffff_ffff_ffff));
    plan.push_back(word_row(16'hfdff, 1'b0));         // scale 63, DC clamps high
    plan.push_back(word_row(16'h0200, 1'b0));         // clamps low
    plan.push_back(word_row(16'h01ff, 1'b0));         // clamps high
    plan.push_back(word_row(16'hf800, 1'b1));         // overshoots 64, end flag is no error
    plan.push_back(load_row(64'h8040_2010_0804_0201));
    plan.push_back(word_row(16'h07ff, 1'b0));         // scale 1, negative DC
    plan.push_back(word_row(16'h03f9, 1'b0));         // negative rounding toward zero
    plan.push_back(word_row(16'h0005, 1'b0));
    plan.push_back(cut_row(16'h0403));                // run word ends input early
    plan.push_back(cut_row(16'h0000));                // header ends input early
    plan.push_back(word_row(16'h0c10, 1'b0));
    plan.push_back(word_row(16'h3c01, 1'b0));
    plan.push_back(word_row(16'hfc00, 1'b0));         // run of 63 closes block
    plan.push_back(word_row(rdzbd_pkg::PAD_WORD, 1'b0)); // skipped between blocks
    plan.push_back(word_row(16'h2801, 1'b0));
    plan.push_back(word_row(16'hfbff, 1'b0));         // lands on the last position
    plan.push_back(word_row(16'h0000, 1'b0));         // reaches exactly 64
    for (int i = 0; i < plan.size(); i++) begin
      row = plan[i];
      if (row.is_load) begin
        reload_qtable(1'b0, row.qval);
      end else begin
        send_word(row.w.code_word, row.w.final_word, row.typed, row.res);
      end
    end

    // Random blocks; hold the receiver off at the start to fill the block
    seq         = 0;
    rx_hold_req = 1'b1;
    while (words_used < RANDOM_WORDS) begin
      tx_calm = (seq >= 5 && seq < 9);
      rx_calm = tx_calm;
      if (seq % 4 == 3 && !blk_open) reload_qtable(1'b1, '0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_block(1'b0);
      end else if (pick < 85) begin
        send_block(1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word(16'($urandom), $urandom_range(0, 7) == 0, 1'b0, '0);
        end
      end
      seq++;
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // Drain and settle
    @(negedge clk);
    word_valid = 1'b0;
    while (coeff_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && coeff_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
